[hdl/ptc_pkg.sv]
package ptc_pkg;

  localparam int DIV_W       = 32;
  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int TEMP_W      = 16;
  localparam int PRESS_W     = 18;
  localparam int UT_W        = 16;
  localparam int UP_W        = 24;

  typedef enum logic [2:0] {
    REG_A1,
    REG_A2,
    REG_A3,
    REG_A4,
    REG_A5,
    REG_A6,
    REG_B_PAIR,
    REG_M_PAIR
  } reg_idx_t;

  localparam logic [31:0] T_OFFSET  = 32'd4000;
  localparam logic [31:0] B4_BIAS   = 32'd32768;
  localparam logic [31:0] P_SQ_GAIN = 32'd3038;
  localparam logic [31:0] P_LIN_K   = 32'hFFFF_E343;
  localparam logic [31:0] P_OFFSET  = 32'd3791;

  localparam logic signed [31:0] TEMP_LO  = -32'sd32768;
  localparam logic signed [31:0] TEMP_HI  = 32'sd32767;
  localparam logic signed [31:0] PRESS_HI = 32'sd262143;

  typedef struct packed {
    logic [31:0]     x1;
    logic [UP_W-1:0] up;
    logic            neg;
    logic            fault;
  } tside_t;

  typedef struct packed {
    logic [31:0] t;
    logic        dbl;
    logic        fault;
  } pside_t;

endpackage

[hdl/ptc_div.sv]
module ptc_div #(
  parameter int SIDE_W = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [ptc_pkg::DIV_W-1:0] in_num,
  input  logic [ptc_pkg::DIV_W-1:0] in_den,
  input  logic [SIDE_W-1:0]         in_side,
  output logic                      out_valid,
  output logic [ptc_pkg::DIV_W-1:0] out_quo,
  output logic [SIDE_W-1:0]         out_side
);
  import ptc_pkg::*;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] nq;
  } step_t;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  function automatic step_t div_step(logic [DIV_W-1:0] rem, logic [DIV_W-1:0] nq,
                                     logic [DIV_W-1:0] den);
    step_t      res;
    logic [DIV_W:0] trial;
    logic       ge;
    trial   = {rem, nq[DIV_W-1]};
    ge      = trial >= {1'b0, den};
    res.rem = ge ? DIV_W'(trial - {1'b0, den}) : trial[DIV_W-1:0];
    res.nq  = {nq[DIV_W-2:0], ge};
    return res;
  endfunction

  logic [DIV_W-1:0]  rem_r  [DIV_W];
  logic [DIV_W-1:0]  nq_r   [DIV_W];
  logic [DIV_W-1:0]  den_r  [DIV_W];
  logic [SIDE_W-1:0] side_r [DIV_W];
  logic [DIV_W-1:0]  vld_r;
  step_t             step_nxt [DIV_W];

  always_comb begin
    step_nxt[0] = div_step('0, in_num, in_den);
    for (int i = 1; i < DIV_W; i++) begin
      step_nxt[i] = div_step(rem_r[i-1], nq_r[i-1], den_r[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
      for (int i = 0; i < DIV_W; i++) begin
        rem_r[i] <= step_nxt[i].rem;
        nq_r[i]  <= step_nxt[i].nq;
      end
      for (int i = 1; i < DIV_W; i++) begin
        den_r[i]  <= den_r[i-1];
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign out_valid = vld_r[DIV_W-1];
  assign out_quo   = nq_r[DIV_W-1];
  assign out_side  = side_r[DIV_W-1];

endmodule

[hdl/pressure_temperature_compensation_unit.sv]
// throughput: one beat per cycle while out_ is not backpressured;
// two 32-stage pipelined dividers set the depth
// backpressure on out_ freezes the whole pipeline; one extra beat is still
// taken into the input register while the pipeline is frozen
// reset: synchronous active-low rst_n clears all valid bits and the coefficients
module pressure_temperature_compensation_unit #(
  parameter int OVERSAMPLING = 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // raw_temperature [15:0], raw_pressure [39:16]
  input  logic [ptc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // temperature [15:0], pressure [33:16], zero [39:34]
  output logic [ptc_pkg::OUT_TDATA_W-1:0] out_tdata,
  // fault [0]
  output logic                            out_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [ptc_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [ptc_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [ptc_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready
);
  import ptc_pkg::*;

  localparam int          UP_SHIFT = 8 - OVERSAMPLING;
  localparam logic [31:0] B7_GAIN  = 32'(50000 >> OVERSAMPLING);

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // configuration registers
  logic [15:0] a1_r, a2_r, a3_r, a4_r, a5_r, a6_r;
  logic [31:0] b_pair_r, m_pair_r;
  logic        cfg_we;
  reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_r     <= '0;
      a2_r     <= '0;
      a3_r     <= '0;
      a4_r     <= '0;
      a5_r     <= '0;
      a6_r     <= '0;
      b_pair_r <= '0;
      m_pair_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_A1:     a1_r     <= cfg_pwdata[15:0];
        REG_A2:     a2_r     <= cfg_pwdata[15:0];
        REG_A3:     a3_r     <= cfg_pwdata[15:0];
        REG_A4:     a4_r     <= cfg_pwdata[15:0];
        REG_A5:     a5_r     <= cfg_pwdata[15:0];
        REG_A6:     a6_r     <= cfg_pwdata[15:0];
        REG_B_PAIR: b_pair_r <= cfg_pwdata;
        REG_M_PAIR: m_pair_r <= cfg_pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_A1:     cfg_prdata = {16'd0, a1_r};
      REG_A2:     cfg_prdata = {16'd0, a2_r};
      REG_A3:     cfg_prdata = {16'd0, a3_r};
      REG_A4:     cfg_prdata = {16'd0, a4_r};
      REG_A5:     cfg_prdata = {16'd0, a5_r};
      REG_A6:     cfg_prdata = {16'd0, a6_r};
      REG_B_PAIR: cfg_prdata = b_pair_r;
      REG_M_PAIR: cfg_prdata = m_pair_r;
      default:    cfg_prdata = '0;
    endcase
  end

  // pipeline control
  logic       adv;
  logic       s0_valid_r;
  logic [1:0] vld_head_r;
  logic [7:0] vld_mid_r;
  logic [3:0] vld_tail_r;
  logic       d1_valid, d2_valid;

  assign adv        = ~out_tvalid | out_tready;
  assign in_tready  = adv | ~s0_valid_r;
  assign out_tvalid = vld_tail_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      vld_head_r <= '0;
      vld_mid_r  <= '0;
      vld_tail_r <= '0;
    end else begin
      if (in_tready) begin
        s0_valid_r <= in_tvalid;
      end
      if (adv) begin
        vld_head_r <= {vld_head_r[0], s0_valid_r};
        vld_mid_r  <= {vld_mid_r[6:0], d1_valid};
        vld_tail_r <= {vld_tail_r[2:0], d2_valid};
      end
    end
  end

  // s0: input register
  logic [UT_W-1:0] s0_ut_r;
  logic [UP_W-1:0] s0_up_r;

  always_ff @(posedge clk) begin
    if (in_tready) begin
      s0_ut_r <= in_tdata[UT_W-1:0];
      s0_up_r <= in_tdata[UT_W+UP_W-1:UT_W];
    end
  end

  // s1: (ut - ac6) * ac5
  logic [31:0]     s1_diff;
  logic [31:0]     s1_prod_r;
  logic [UP_W-1:0] s1_up_r;

  assign s1_diff = {16'd0, s0_ut_r} - {16'd0, a6_r};

  // s2: temperature divisor setup
  logic [31:0] s2_x1, s2_den, s2_num, s2_mag_n, s2_mag_d;
  logic        s2_zero;
  logic [31:0] s2_num_r, s2_den_r;
  tside_t      s2_side_r;

  always_comb begin
    s2_x1    = 32'($signed(s1_prod_r) >>> 15);
    s2_den   = s2_x1 + sx16(m_pair_r[15:0]);
    s2_num   = sx16(m_pair_r[31:16]) << 11;
    s2_zero  = s2_den == '0;
    s2_mag_n = s2_num[31] ? 32'd0 - s2_num : s2_num;
    s2_mag_d = s2_zero ? 32'd1 : (s2_den[31] ? 32'd0 - s2_den : s2_den);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod_r       <= s1_diff * {16'd0, a5_r};
      s1_up_r         <= s0_up_r;
      s2_num_r        <= s2_mag_n;
      s2_den_r        <= s2_mag_d;
      s2_side_r.x1    <= s2_x1;
      s2_side_r.up    <= s1_up_r;
      s2_side_r.neg   <= s2_num[31] ^ s2_den[31];
      s2_side_r.fault <= s2_zero;
    end
  end

  logic [31:0] d1_quo;
  tside_t      d1_side;

  ptc_div #(
    .SIDE_W ($bits(tside_t))
  ) u_tdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (vld_head_r[1]),
    .in_num    (s2_num_r),
    .in_den    (s2_den_r),
    .in_side   (s2_side_r),
    .out_valid (d1_valid),
    .out_quo   (d1_quo),
    .out_side  (d1_side)
  );

  // s3..s10: temperature and pressure coefficients
  logic [31:0]     s3_x2;
  logic [31:0]     s3_b5_r;
  logic [UP_W-1:0] s3_up_r;
  logic            s3_fault_r;

  logic [31:0]     s4_t10;
  logic [31:0]     s4_t_r, s4_b6_r;
  logic [UP_W-1:0] s4_up_r;
  logic            s4_fault_r;

  logic [31:0]     s5_sqp_r, s5_a2b6_r, s5_a3b6_r, s5_t_r;
  logic [UP_W-1:0] s5_up_r;
  logic            s5_fault_r;

  logic [31:0]     s6_sq;
  logic [31:0]     s6_b2sq_r, s6_b1sq_r, s6_x2a_r, s6_x1b_r, s6_t_r;
  logic [UP_W-1:0] s6_up_r;
  logic            s6_fault_r;

  logic [31:0]     s7_x3_r, s7_sum_r, s7_t_r;
  logic [UP_W-1:0] s7_up_r;
  logic            s7_fault_r;

  logic [31:0]     s8_pre;
  logic [31:0]     s8_b3_r, s8_varg_r, s8_t_r;
  logic [UP_W-1:0] s8_up_r;
  logic            s8_fault_r;

  logic [31:0]     s9_prod;
  logic [31:0]     s9_b4_r, s9_t7_r, s9_t_r;
  logic            s9_fault_r;

  logic [31:0]     s10_b7_r, s10_b4_r, s10_t_r;
  logic            s10_fault_r;

  assign s3_x2   = d1_side.neg ? 32'd0 - d1_quo : d1_quo;
  assign s4_t10  = (s3_b5_r << 3) + (s3_b5_r << 1) + 32'd8;
  assign s6_sq   = 32'($signed(s5_sqp_r) >>> 12);
  assign s8_pre  = (((sx16(a1_r) << 2) + s7_x3_r) << OVERSAMPLING) + 32'd2;
  assign s9_prod = {16'd0, a4_r} * s8_varg_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_b5_r     <= d1_side.x1 + s3_x2;
      s3_up_r     <= d1_side.up;
      s3_fault_r  <= d1_side.fault;

      s4_t_r      <= 32'($signed(s4_t10) >>> 4);
      s4_b6_r     <= s3_b5_r - T_OFFSET;
      s4_up_r     <= s3_up_r;
      s4_fault_r  <= s3_fault_r;

      s5_sqp_r    <= s4_b6_r * s4_b6_r;
      s5_a2b6_r   <= sx16(a2_r) * s4_b6_r;
      s5_a3b6_r   <= sx16(a3_r) * s4_b6_r;
      s5_t_r      <= s4_t_r;
      s5_up_r     <= s4_up_r;
      s5_fault_r  <= s4_fault_r;

      s6_b2sq_r   <= sx16(b_pair_r[15:0]) * s6_sq;
      s6_b1sq_r   <= sx16(b_pair_r[31:16]) * s6_sq;
      s6_x2a_r    <= 32'($signed(s5_a2b6_r) >>> 11);
      s6_x1b_r    <= 32'($signed(s5_a3b6_r) >>> 13);
      s6_t_r      <= s5_t_r;
      s6_up_r     <= s5_up_r;
      s6_fault_r  <= s5_fault_r;

      s7_x3_r     <= 32'($signed(s6_b2sq_r) >>> 11) + s6_x2a_r;
      s7_sum_r    <= s6_x1b_r + 32'($signed(s6_b1sq_r) >>> 16) + 32'd2;
      s7_t_r      <= s6_t_r;
      s7_up_r     <= s6_up_r;
      s7_fault_r  <= s6_fault_r;

      s8_b3_r     <= 32'($signed(s8_pre) >>> 2);
      s8_varg_r   <= 32'($signed(s7_sum_r) >>> 2) + B4_BIAS;
      s8_t_r      <= s7_t_r;
      s8_up_r     <= s7_up_r;
      s8_fault_r  <= s7_fault_r;

      s9_b4_r     <= s9_prod >> 15;
      s9_t7_r     <= ({8'd0, s8_up_r} >> UP_SHIFT) - s8_b3_r;
      s9_t_r      <= s8_t_r;
      s9_fault_r  <= s8_fault_r;

      s10_b7_r    <= s9_t7_r * B7_GAIN;
      s10_b4_r    <= s9_b4_r;
      s10_t_r     <= s9_t_r;
      s10_fault_r <= s9_fault_r | (s9_b4_r == '0);
    end
  end

  // pressure division: large b7 divides first, then doubles
  logic [31:0] d2_num, d2_den;
  pside_t      d2_in_side;
  logic [31:0] d2_quo;
  pside_t      d2_side;

  always_comb begin
    d2_num           = s10_b7_r[31] ? s10_b7_r : s10_b7_r << 1;
    d2_den           = (s10_b4_r == '0) ? 32'd1 : s10_b4_r;
    d2_in_side.t     = s10_t_r;
    d2_in_side.dbl   = s10_b7_r[31];
    d2_in_side.fault = s10_fault_r;
  end

  ptc_div #(
    .SIDE_W ($bits(pside_t))
  ) u_pdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (vld_mid_r[7]),
    .in_num    (d2_num),
    .in_den    (d2_den),
    .in_side   (d2_in_side),
    .out_valid (d2_valid),
    .out_quo   (d2_quo),
    .out_side  (d2_side)
  );

  // s11..s14: pressure correction, saturation, output register
  logic [31:0] s11_p, s11_p8;
  logic [31:0] s11_p_r, s11_pp_r, s11_x2p_r, s11_t_r;
  logic        s11_fault_r;

  logic [31:0] s12_m_r, s12_x2_r, s12_p_r, s12_t_r;
  logic        s12_fault_r;

  logic [31:0] s13_sum_r, s13_p_r, s13_t_r;
  logic        s13_fault_r;

  logic [31:0]        s14_pr;
  logic [TEMP_W-1:0]  s14_temp;
  logic [PRESS_W-1:0] s14_press;
  logic [TEMP_W-1:0]  out_temp_r;
  logic [PRESS_W-1:0] out_press_r;
  logic               out_fault_r;

  assign s11_p  = d2_side.dbl ? d2_quo << 1 : d2_quo;
  assign s11_p8 = 32'($signed(s11_p) >>> 8);
  assign s14_pr = s13_p_r + 32'($signed(s13_sum_r) >>> 4);

  always_comb begin
    if ($signed(s13_t_r) < TEMP_LO) begin
      s14_temp = TEMP_LO[TEMP_W-1:0];
    end else if ($signed(s13_t_r) > TEMP_HI) begin
      s14_temp = TEMP_HI[TEMP_W-1:0];
    end else begin
      s14_temp = s13_t_r[TEMP_W-1:0];
    end
    if ($signed(s14_pr) < 0) begin
      s14_press = '0;
    end else if ($signed(s14_pr) > PRESS_HI) begin
      s14_press = PRESS_HI[PRESS_W-1:0];
    end else begin
      s14_press = s14_pr[PRESS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s11_p_r     <= s11_p;
      s11_pp_r    <= s11_p8 * s11_p8;
      s11_x2p_r   <= s11_p * P_LIN_K;
      s11_t_r     <= d2_side.t;
      s11_fault_r <= d2_side.fault;

      s12_m_r     <= s11_pp_r * P_SQ_GAIN;
      s12_x2_r    <= 32'($signed(s11_x2p_r) >>> 16);
      s12_p_r     <= s11_p_r;
      s12_t_r     <= s11_t_r;
      s12_fault_r <= s11_fault_r;

      s13_sum_r   <= 32'($signed(s12_m_r) >>> 16) + s12_x2_r + P_OFFSET;
      s13_p_r     <= s12_p_r;
      s13_t_r     <= s12_t_r;
      s13_fault_r <= s12_fault_r;

      out_temp_r  <= s13_fault_r ? '0 : s14_temp;
      out_press_r <= s13_fault_r ? '0 : s14_press;
      out_fault_r <= s13_fault_r;
    end
  end

  assign out_tdata = {(OUT_TDATA_W - TEMP_W - PRESS_W)'(0), out_press_r, out_temp_r};
  assign out_tuser = out_fault_r;

  // a faulted beat carries zero data
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[TEMP_W+PRESS_W-1:0] == '0)
    else $error("fault beat with nonzero data");

  // backpressure freezes the middle of the pipeline
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> vld_mid_r == $past(vld_mid_r))
    else $error("pipeline moved while stalled");

  // the temperature divider never sees a zero divisor
  a_tdiv_den: assert property (@(posedge clk) disable iff (!rst_n)
    vld_head_r[1] |-> s2_den_r != '0)
    else $error("zero temperature divisor");

  // a zero pressure divisor is always flagged as a fault
  a_pdiv_fault: assert property (@(posedge clk) disable iff (!rst_n)
    vld_mid_r[7] && s10_b4_r == '0 |-> s10_fault_r)
    else $error("zero pressure divisor without fault");

endmodule
